>>> rtl/core/error_diffusion_seed_placer_core_defines.svh
// Assertion macros for the error diffusion seed placer.
// Expect clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef ERROR_DIFFUSION_SEED_PLACER_CORE_DEFINES_SVH
`define ERROR_DIFFUSION_SEED_PLACER_CORE_DEFINES_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define EDSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define EDSP_ASSERT_NEVER(lbl, expr, msg) \
  `EDSP_ASSERT(lbl, !(expr), msg)

`endif

>>> rtl/core/edsp_pkg.sv
// Shared constants and types of the error diffusion seed placer.
// No dependencies.
package edsp_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  // stream field widths
  localparam int DENSITY_W  = 18;
  localparam int RADIUS_W   = 16;
  localparam int SEED_XY_W  = 10;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 40;
  localparam int SAMPLE_FRAC = 16;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // size clamping
  localparam int CLAMP_W    = 13;
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  // error format: FRAC_BITS fraction bits plus integer bits
  localparam int ERR_INT_BITS = 6;

  // Floyd-Steinberg weights, in sixteenths
  localparam int WGT_RIGHT      = 7;
  localparam int WGT_DOWN_LEFT  = 3;
  localparam int WGT_DOWN       = 5;
  localparam int WGT_DOWN_RIGHT = 1;
  localparam int WGT_SHIFT      = 4;
  localparam int WGT_ROUND      = 8;

  // position of a pixel within the frame
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic first_col;
    logic second_col;
    logic last_col;
  } scan_flags_t;

endpackage

>>> rtl/core/edsp_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module edsp_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/edsp_scan.sv
// Raster position counters and frame size registers.
// Depends on edsp_pkg.
module edsp_scan #(
  parameter int MAX_WIDTH  = edsp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = edsp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [edsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [edsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            advance_i,
  output logic [$clog2(MAX_WIDTH)-1:0]    x_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]   y_o,
  output edsp_pkg::scan_flags_t           flags_o,
  output logic                            clear_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = edsp_pkg::CLAMP_W;

  logic [edsp_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [CW-1:0] w_ext, h_ext;
  logic [XW:0]   w_eff;
  logic [YW:0]   h_eff;
  logic          last_col, last_row;

  assign clear_o = cfg_we_i && (cfg_index_i == edsp_pkg::CFG_IMAGE_WIDTH ||
                                cfg_index_i == edsp_pkg::CFG_IMAGE_HEIGHT);

  // clamp sizes to the supported range
  always_comb begin
    w_ext = CW'(width_q);
    h_ext = CW'(height_q);
    if (w_ext < CW'(edsp_pkg::MIN_WIDTH)) begin
      w_eff = (XW+1)'(edsp_pkg::MIN_WIDTH);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(w_ext);
    end
    if (h_ext < CW'(edsp_pkg::MIN_HEIGHT)) begin
      h_eff = (YW+1)'(edsp_pkg::MIN_HEIGHT);
    end else if (h_ext > CW'(MAX_HEIGHT)) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(h_ext);
    end
  end

  assign last_col = ({1'b0, x_q} + (XW+1)'(1)) == w_eff;
  assign last_row = ({1'b0, y_q} + (YW+1)'(1)) == h_eff;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    priority if (clear_o) begin
      x_d = '0;
      y_d = '0;
    end else if (advance_i) begin
      if (last_col) begin
        x_d = '0;
        y_d = last_row ? '0 : y_q + YW'(1);
      end else begin
        x_d = x_q + XW'(1);
      end
    end else begin
      x_d = x_q;
      y_d = y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= edsp_pkg::IMAGE_WIDTH_RST;
      height_q <= edsp_pkg::IMAGE_HEIGHT_RST;
      x_q      <= '0;
      y_q      <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == edsp_pkg::CFG_IMAGE_WIDTH) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_index_i == edsp_pkg::CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_wdata_i;
      end
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o                = x_q;
  assign y_o                = y_q;
  assign flags_o.first_row  = (y_q == '0);
  assign flags_o.last_row   = last_row;
  assign flags_o.first_col  = (x_q == '0);
  assign flags_o.second_col = (x_q == XW'(1));
  assign flags_o.last_col   = last_col;

endmodule

>>> rtl/core/edsp_diffuse.sv
// Diffusion stage: combines line-store error, runs threshold and weights,
// writes back the next-row error and holds the seed output register.
// Depends on edsp_pkg.
module edsp_diffuse #(
  parameter int MAX_WIDTH  = edsp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = edsp_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = edsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  logic [edsp_pkg::DENSITY_W-1:0]      density_i,
  input  logic [edsp_pkg::RADIUS_W-1:0]       radius_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]        x_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]       y_i,
  input  edsp_pkg::scan_flags_t               flags_i,
  input  logic [FRAC_BITS+edsp_pkg::ERR_INT_BITS-1:0] ram_rdata_i,
  output logic                                ram_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        ram_waddr_o,
  output logic [FRAC_BITS+edsp_pkg::ERR_INT_BITS-1:0] ram_wdata_o,
  output logic                                advance_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [edsp_pkg::SEED_XY_W-1:0]      seed_x_o,
  output logic [edsp_pkg::SEED_XY_W-1:0]      seed_y_o,
  output logic [edsp_pkg::RADIUS_W-1:0]       seed_radius_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int EW = FRAC_BITS + edsp_pkg::ERR_INT_BITS;
  localparam int SW = EW + 4;
  localparam logic signed [SW-1:0] SatHi = SW'((1 <<< (EW - 1)) - 1);
  localparam logic signed [SW-1:0] SatLo = -SatHi - SW'(1);
  localparam logic signed [EW-1:0] Half  = EW'(1 <<< (FRAC_BITS - 1));
  localparam logic signed [EW-1:0] One   = EW'(1 <<< FRAC_BITS);

  function automatic logic signed [EW-1:0] sat(input logic signed [SW-1:0] a);
    logic signed [EW-1:0] r;
    if (a > SatHi) begin
      r = SatHi[EW-1:0];
    end else if (a < SatLo) begin
      r = SatLo[EW-1:0];
    end else begin
      r = a[EW-1:0];
    end
    return r;
  endfunction

  // k/16 of v, rounded to nearest with ties upward
  function automatic logic signed [EW-1:0] wgt(input logic signed [EW-1:0] v, input int k);
    logic signed [SW-1:0] p;
    p = SW'(v) * SW'(k) + SW'(edsp_pkg::WGT_ROUND);
    return sat(p >>> edsp_pkg::WGT_SHIFT);
  endfunction

  // pixel register (read issued at accept, data arrives here)
  logic                             b_valid_q;
  logic [edsp_pkg::DENSITY_W-1:0]   b_density_q;
  logic [edsp_pkg::RADIUS_W-1:0]    b_radius_q;
  logic [XW-1:0]                    b_x_q;
  logic [YW-1:0]                    b_y_q;
  edsp_pkg::scan_flags_t            b_flags_q;

  // diffusion state
  logic signed [EW-1:0] right_q, right_d;
  logic signed [EW-1:0] pend_left_q, pend_left_d;
  logic signed [EW-1:0] pend_here_q, pend_here_d;
  logic signed [EW-1:0] col0_q, col0_d;
  logic signed [EW-1:0] coll_q, coll_d;

  // output register
  logic                          out_valid_q;
  logic [edsp_pkg::SEED_XY_W-1:0] out_x_q, out_y_q;
  logic [edsp_pkg::RADIUS_W-1:0]  out_radius_q;

  logic signed [EW-1:0] sfix, stored, v, vs, w_dl;
  logic                 out_free, advance, accept, middle, seed_hit, seed;

  assign out_free  = !out_valid_q || m_ready_i;
  assign advance   = b_valid_q && out_free;
  assign s_ready_o = !b_valid_q || out_free;
  assign accept    = s_valid_i && s_ready_o;
  assign advance_o = advance;

  // density in error format
  if (FRAC_BITS >= edsp_pkg::SAMPLE_FRAC) begin : g_up
    assign sfix = EW'(b_density_q) <<< (FRAC_BITS - edsp_pkg::SAMPLE_FRAC);
  end else begin : g_dn
    assign sfix = EW'(b_density_q >> (edsp_pkg::SAMPLE_FRAC - FRAC_BITS));
  end

  always_comb begin
    // first row always sees a clean line store
    priority if (b_flags_q.first_row) begin
      stored = '0;
    end else if (b_flags_q.first_col) begin
      stored = col0_q;
    end else if (b_flags_q.last_col) begin
      stored = coll_q;
    end else begin
      stored = ram_rdata_i;
    end

    v        = sat(SW'(sfix) + SW'(stored) + SW'(right_q));
    seed_hit = (v >= Half);
    vs       = seed_hit ? v - One : v;   // stays above the lower bound
    w_dl     = wgt(vs, edsp_pkg::WGT_DOWN_LEFT);
    middle   = !b_flags_q.last_row && !b_flags_q.first_col && !b_flags_q.last_col;
    seed     = advance && middle && seed_hit;

    right_d     = right_q;
    pend_left_d = pend_left_q;
    pend_here_d = pend_here_q;
    col0_d      = col0_q;
    coll_d      = coll_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = b_x_q - XW'(1);
    ram_wdata_o = sat(SW'(pend_left_q) + SW'(w_dl));

    if (advance) begin
      priority if (b_flags_q.last_row) begin
        right_d     = '0;
        pend_left_d = '0;
        pend_here_d = '0;
      end else if (b_flags_q.first_col) begin
        right_d     = v;
        pend_left_d = '0;
        pend_here_d = '0;
      end else if (!b_flags_q.last_col) begin
        right_d     = wgt(vs, edsp_pkg::WGT_RIGHT);
        ram_we_o    = 1'b1;
        if (b_flags_q.second_col) begin
          col0_d = ram_wdata_o;
        end
        pend_left_d = sat(SW'(pend_here_q) + SW'(wgt(vs, edsp_pkg::WGT_DOWN)));
        pend_here_d = wgt(vs, edsp_pkg::WGT_DOWN_RIGHT);
      end else begin
        // row end: flush pendings, fold the total into column 0
        ram_we_o    = 1'b1;
        ram_wdata_o = pend_left_q;
        coll_d      = pend_here_q;
        col0_d      = sat(SW'(col0_q) + SW'(v));
        right_d     = '0;
        pend_left_d = '0;
        pend_here_d = '0;
      end
    end

    if (clear_i) begin
      right_d     = '0;
      pend_left_d = '0;
      pend_here_d = '0;
      col0_d      = '0;
      coll_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      right_q     <= '0;
      pend_left_q <= '0;
      pend_here_q <= '0;
      col0_q      <= '0;
      coll_q      <= '0;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (advance) begin
        b_valid_q <= 1'b0;
      end
      if (seed) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      right_q     <= right_d;
      pend_left_q <= pend_left_d;
      pend_here_q <= pend_here_d;
      col0_q      <= col0_d;
      coll_q      <= coll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_density_q <= density_i;
      b_radius_q  <= radius_i;
      b_x_q       <= x_i;
      b_y_q       <= y_i;
      b_flags_q   <= flags_i;
    end
    if (seed) begin
      out_x_q      <= edsp_pkg::SEED_XY_W'(b_x_q);
      out_y_q      <= edsp_pkg::SEED_XY_W'(b_y_q);
      out_radius_q <= b_radius_q;
    end
  end

  assign m_valid_o     = out_valid_q;
  assign seed_x_o      = out_x_q;
  assign seed_y_o      = out_y_q;
  assign seed_radius_o = out_radius_q;

endmodule

>>> rtl/core/error_diffusion_seed_placer_core.sv
// Top level of the error diffusion seed placer: scan counters, line store
// RAM and diffusion stage. Depends on edsp_pkg, edsp_scan, edsp_diffuse,
// edsp_ram and error_diffusion_seed_placer_core_defines.svh.

// Floyd-Steinberg seed placer. Pixels enter in raster order, one word per
// pixel, and the block takes one pixel every clock cycle; it pauses only
// while a seed sits in the output register and the sink does not take it.
// A pixel passes an accept stage, in which the next-row error of its
// column is read from the line store RAM, and then the pixel register stage,
// in which the error is combined, thresholded at one half and diffused, and a seed (if
// any) is loaded into the output register. The pace is set by the
// right-neighbour error loop, closed inside the pixel register stage, and by the
// single RAM write port, which takes one next-row entry per pixel.
// Columns 0 and width-1 of the line store live in registers. Row 0 ignores
// the line store, so no clearing pass is needed after reset or after a
// size write; a write to image_width or image_height restarts the frame.
// Column 0, the last column and the last row of a frame never seed.

`include "error_diffusion_seed_placer_core_defines.svh"

module error_diffusion_seed_placer_core #(
  parameter int MAX_WIDTH  = edsp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = edsp_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = edsp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [edsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [edsp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [17:0] density_sample, [33:18] cluster_radius, [39:34] zero
  input  logic [edsp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // seed stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [9:0] seed_x, [19:10] seed_y, [35:20] seed_radius, [39:36] zero
  output logic [edsp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int EW = FRAC_BITS + edsp_pkg::ERR_INT_BITS;
  localparam int DW = edsp_pkg::DENSITY_W;
  localparam int RW = edsp_pkg::RADIUS_W;
  localparam int PW = edsp_pkg::SEED_XY_W;

  logic [XW-1:0]         scan_x;
  logic [YW-1:0]         scan_y;
  edsp_pkg::scan_flags_t scan_flags;
  logic                  clear;
  logic                  accept;
  logic                  advance;

  // line store ports
  logic          ram_we, ram_re;
  logic [XW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [PW-1:0] seed_x, seed_y;
  logic [RW-1:0] seed_radius;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign ram_re    = accept;      // read the column of the pixel being taken
  assign ram_raddr = scan_x;

  edsp_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (accept),
    .x_o         (scan_x),
    .y_o         (scan_y),
    .flags_o     (scan_flags),
    .clear_o     (clear)
  );

  edsp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  edsp_diffuse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_diffuse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (clear),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .density_i     (s_axis_tdata[DW-1:0]),
    .radius_i      (s_axis_tdata[DW+RW-1:DW]),
    .x_i           (scan_x),
    .y_i           (scan_y),
    .flags_i       (scan_flags),
    .ram_rdata_i   (ram_rdata),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .advance_o     (advance),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .seed_x_o      (seed_x),
    .seed_y_o      (seed_y),
    .seed_radius_o (seed_radius)
  );

  assign m_axis_tdata = {(edsp_pkg::M_TDATA_W - 2*PW - RW)'(0), seed_radius, seed_y, seed_x};

  // A pixel never reads the entry that the previous pixel writes back.
  `EDSP_ASSERT_NEVER(a_ram_same_entry, ram_we && ram_re && (ram_waddr == ram_raddr), "RAM clash")

  // Line store is written only while a pixel leaves the diffusion stage.
  `EDSP_ASSERT(a_ram_write_on_advance, ram_we |-> advance, "line store write without a pixel")

  // A size write sends the scan back to the frame origin.
  `EDSP_ASSERT(a_clear_home, clear |=> (scan_x == '0 && scan_y == '0), "frame not restarted")

  // A new seed only appears when a pixel has left the diffusion stage.
  `EDSP_ASSERT(a_seed_source, $rose(m_axis_tvalid) |-> $past(advance), "seed without a pixel")

endmodule

>>> sim/tb.sv
// Self-checking bench for error_diffusion_seed_placer_core: streams pixel words,
// predicts the seed stream with a Floyd-Steinberg diffusion model and scores it.
// Depends on edsp_pkg and the core RTL.
module tb;
  import edsp_pkg::*;

  // error format and fixed-point levels
  localparam int     ERR_W  = FRAC_BITS_DEF + ERR_INT_BITS;
  localparam longint ERR_HI = (longint'(1) << (ERR_W - 1)) - 1;
  localparam longint ERR_LO = -(longint'(1) << (ERR_W - 1));
  localparam longint HALF   = longint'(1) << (FRAC_BITS_DEF - 1);
  localparam longint ONE    = longint'(1) << FRAC_BITS_DEF;

  localparam int unsigned DENSITY_MAX = (1 << DENSITY_W) - 1;
  localparam int unsigned RADIUS_MAX  = (1 << RADIUS_W) - 1;
  localparam int unsigned CFG_MAX     = (1 << CFG_DATA_W) - 1;
  localparam int unsigned IDX_TOP     = (1 << CFG_IDX_W) - 1;

  // pipeline is two deep; this is ample for the last pixel to retire
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  // 3x2 frames: corner values, exact half, just below half, saturation
  localparam int NUM_EDGE = 18;
  localparam int unsigned EDGE_DENSITY [NUM_EDGE] = '{
    DENSITY_MAX, 0, DENSITY_MAX, 'h8000, DENSITY_MAX, 0,
    0, 'h8000, 0, 'h7FFF, 'h10000, DENSITY_MAX,
    0, 'h7FFF, 1, 'h20000, 0, 'h8000};
  localparam int unsigned EDGE_RADIUS [NUM_EDGE] = '{
    0, 'hFFFF, 'hA5A5, 1, 'hFFFF, 0,
    0, 'h5A5A, 0, 'h8000, 'h00FF, 'hFF00,
    0, 'hFFFF, 'h1234, 'h7FFF, 0, 'hC3C3};

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]  radius;
    logic [DENSITY_W-1:0] density;
  } pixel_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]  radius;
    logic [SEED_XY_W-1:0] y;
    logic [SEED_XY_W-1:0] x;
  } seed_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  pixel_t drv_pixel = '0;
  seed_t  seed_out;

  // density in the low bits, radius above, zero fill to the top
  assign s_axis_tdata = S_TDATA_W'(drv_pixel);
  assign seed_out     = seed_t'(m_axis_tdata[$bits(seed_t)-1:0]);

  error_diffusion_seed_placer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Diffusion model: its own copy of the line store, the running errors,
  // the scan position and the two size registers.
  // ---------------------------------------------------------------------
  err_t                  line_err [MAX_WIDTH_DEF];
  err_t                  carry_right, pend_left, pend_here;
  int unsigned           scan_x, scan_y;
  logic [CFG_DATA_W-1:0] width_reg  = IMAGE_WIDTH_RST;
  logic [CFG_DATA_W-1:0] height_reg = IMAGE_HEIGHT_RST;
  seed_t                 seeds_due [$];

  pixel_t pixel_q [$];
  int     pixels_queued = 0;
  int     pixels_taken  = 0;
  bit     word_accepted = 1'b0;
  int     mismatches    = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     phase_no       = 0;
  int     hold_req = 0;
  int     hold_ack = 0;
  int     hold_left = 0;

  function automatic err_t clip_err(longint a);
    if (a > ERR_HI) return err_t'(ERR_HI);
    if (a < ERR_LO) return err_t'(ERR_LO);
    return err_t'(a);
  endfunction

  // w/16 of v, rounded to nearest with ties up (arithmetic shift = floor)
  function automatic err_t fs_share(int unsigned wgt, err_t v);
    longint p;
    p = longint'(wgt) * longint'(v) + WGT_ROUND;
    return clip_err(p >>> WGT_SHIFT);
  endfunction

  function automatic void restart_frame();
    foreach (line_err[i]) line_err[i] = '0;
    carry_right = '0;
    pend_left   = '0;
    pend_here   = '0;
    scan_x      = 0;
    scan_y      = 0;
  endfunction

  function automatic void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = val;
      restart_frame();
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = val;
      restart_frame();
    end
  endfunction

  // one pixel through the diffusion; queues a seed when one is placed
  function automatic void diffuse_pixel(pixel_t p);
    int unsigned w, h, x, y;
    err_t        stored, v;
    seed_t       s;
    w = (width_reg < MIN_WIDTH) ? MIN_WIDTH :
        (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    h = (height_reg < MIN_HEIGHT) ? MIN_HEIGHT :
        (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
    x = (scan_x >= w) ? w - 1 : scan_x;
    y = (scan_y >= h) ? h - 1 : scan_y;
    stored      = line_err[x];
    line_err[x] = '0;
    if (y + 1 < h) begin
      // sample is Q2.16, same fraction as the error format
      v = clip_err(longint'(p.density) + longint'(stored) + longint'(carry_right));
      if (x == 0) begin
        // column 0 folds whole into column 1
        carry_right = v;
        pend_left   = '0;
        pend_here   = '0;
      end else if (x + 1 < w) begin
        if (longint'(v) >= HALF) begin
          v        = clip_err(longint'(v) - ONE);
          s.x      = SEED_XY_W'(x);
          s.y      = SEED_XY_W'(y);
          s.radius = p.radius;
          seeds_due = {seeds_due, s};
        end
        carry_right     = fs_share(WGT_RIGHT, v);
        line_err[x - 1] = clip_err(longint'(pend_left) + longint'(fs_share(WGT_DOWN_LEFT, v)));
        pend_left       = clip_err(longint'(pend_here) + longint'(fs_share(WGT_DOWN, v)));
        pend_here       = fs_share(WGT_DOWN_RIGHT, v);
      end else begin
        // last column: flush pending entries, carry the total into column 0
        line_err[x - 1] = pend_left;
        line_err[x]     = pend_here;
        line_err[0]     = clip_err(longint'(line_err[0]) + longint'(v));
        carry_right     = '0;
        pend_left       = '0;
        pend_here       = '0;
      end
    end else begin
      // final row only drains the line store
      carry_right = '0;
      pend_left   = '0;
      pend_here   = '0;
    end
    if (x + 1 < w) begin
      scan_x = x + 1;
      scan_y = y;
    end else begin
      scan_x = 0;
      scan_y = (y + 1 < h) ? y + 1 : 0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Pixel driver: a word is taken at the rising edge, the next one is
  // offered at the falling edge.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : pixel_accept
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      diffuse_pixel(drv_pixel);
      pixels_taken++;
      word_accepted = 1'b1;
    end
  end

  always @(negedge clk_i) begin : pixel_driver
    if (rst_ni && (!s_axis_tvalid || word_accepted)) begin
      word_accepted = 1'b0;
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_pixel     <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Seed sink: random stalls, plus a long hold-off on request so that the
  // output register fills and the core backs up its input.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin : seed_receiver
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every seed word is matched field by field against the oldest prediction
  always @(posedge clk_i) begin : seed_monitor
    seed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (seeds_due.size() == 0) begin
        $display("%0t: seed expected none got x=%0d y=%0d radius=%h", $time,
                 seed_out.x, seed_out.y, seed_out.radius);
        mismatches++;
      end else begin
        want = seeds_due.pop_front();
        if (seed_out.x !== want.x) begin
          $display("%0t: seed_x expected %0d got %0d", $time, want.x, seed_out.x);
          mismatches++;
        end
        if (seed_out.y !== want.y) begin
          $display("%0t: seed_y expected %0d got %0d", $time, want.y, seed_out.y);
          mismatches++;
        end
        if (seed_out.radius !== want.radius) begin
          $display("%0t: seed_radius expected %h got %h", $time, want.radius,
                   seed_out.radius);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------
  task automatic queue_pixel(input int unsigned dens, input int unsigned rad);
    pixel_t p;
    p.density = DENSITY_W'(dens);
    p.radius  = RADIUS_W'(rad);
    pixel_q = {pixel_q, p};
    pixels_queued++;
  endtask

  // mostly sub-unity densities, with zeros, full-scale and saturating spikes
  task automatic queue_random_pixel();
    int unsigned d;
    case ($urandom_range(15))
      0, 1:    d = 0;
      2:       d = DENSITY_MAX;
      3:       d = $urandom_range(DENSITY_MAX);
      default: d = $urandom_range('hC000);
    endcase
    queue_pixel(d, $urandom_range(RADIUS_MAX));
  endtask

  task automatic wait_drained();
    while (pixels_taken != pixels_queued || seeds_due.size() != 0) @(negedge clk_i);
  endtask

  // size writes only while the core is empty
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    write_size(idx, CFG_DATA_W'(val));
  endtask

  // rotate: no idling, sender idle, sink stalling, both
  task automatic select_idle();
    @(posedge clk_i);
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
    phase_no++;
  endtask

  task automatic run_phase(input int unsigned wv, input int unsigned hv, input int unsigned n);
    int unsigned k;
    cfg_write(CFG_IMAGE_WIDTH, wv);
    cfg_write(CFG_IMAGE_HEIGHT, hv);
    select_idle();
    for (k = 0; k < n; k++) begin
      if (k == n / 2 && $urandom_range(1) == 1) begin
        // sender pauses until the core is empty; sometimes poke an unused index
        wait_drained();
        if ($urandom_range(1) == 1)
          cfg_write(CFG_IDX_W'($urandom_range(CFG_IMAGE_HEIGHT + 1, IDX_TOP)),
                    $urandom_range(CFG_MAX));
        @(posedge clk_i);
      end
      queue_random_pixel();
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int unsigned k, wv, hv;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset sizes (640x480): a few words in row 0
    @(posedge clk_i);
    queue_pixel(DENSITY_MAX, RADIUS_MAX);
    queue_pixel(0, 0);
    queue_pixel('h8000, 'h5555);
    queue_pixel(0, 'hAAAA);
    wait_drained();

    // smallest frame, three times over: final row, wrap to (0,0)
    cfg_write(CFG_IMAGE_WIDTH, MIN_WIDTH);
    cfg_write(CFG_IMAGE_HEIGHT, MIN_HEIGHT);
    select_idle();
    for (k = 0; k < NUM_EDGE; k++) queue_pixel(EDGE_DENSITY[k], EDGE_RADIUS[k]);
    wait_drained();

    // size extremes, including values that clamp
    run_phase(MIN_WIDTH - 1, 0, 20);
    run_phase(CFG_MAX, MIN_HEIGHT + 1, 1030);
    run_phase(MAX_WIDTH_DEF, MIN_HEIGHT, 20);
    run_phase(MIN_WIDTH, MAX_HEIGHT_DEF, 40);
    run_phase(5, CFG_MAX, 30);

    // back-pressure: dense pixels while the sink holds off for a long stretch
    cfg_write(CFG_IMAGE_WIDTH, 8);
    cfg_write(CFG_IMAGE_HEIGHT, 6);
    @(posedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (k = 0; k < 60; k++) queue_pixel(DENSITY_MAX, $urandom_range(RADIUS_MAX));
    hold_req++;
    wait_drained();

    // random small frames
    for (k = 0; k < 5; k++) begin
      case ($urandom_range(5))
        0:       wv = $urandom_range(MIN_WIDTH - 1);
        1:       wv = $urandom_range(MAX_WIDTH_DEF + 1, CFG_MAX);
        default: wv = $urandom_range(MIN_WIDTH, 16);
      endcase
      hv = $urandom_range(0, 6);
      // wide frames get few rows
      if (wv > MAX_WIDTH_DEF) hv = MIN_HEIGHT;
      run_phase(wv, hv, $urandom_range(8, 24));
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
